// File: rtl/am_fm_tuner_controller_assert.svh
// assertion macros shared by the tuner controller rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef AM_FM_TUNER_CONTROLLER_ASSERT_SVH
`define AM_FM_TUNER_CONTROLLER_ASSERT_SVH

// same-cycle implication, checks off during reset
`define AMFM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amfm check failed");

// next-cycle implication, checks off during reset
`define AMFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amfm check failed");

`endif

// File: rtl/amfm_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and reset constants of the tuner controller
// used by the interfaces and every module of the block
package amfm_pkg;

  localparam int PRESETS      = 5;
  localparam int PRESET_IDX_W = (PRESETS > 1) ? $clog2(PRESETS) : 1;
  localparam int ST_W         = 12;
  localparam int STEP_W       = 8;
  localparam int VOL_W        = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;

  localparam logic [ST_W-1:0]   AM_LOW_RST  = 12'd530;
  localparam logic [ST_W-1:0]   AM_HIGH_RST = 12'd1700;
  localparam logic [STEP_W-1:0] AM_STEP_RST = 8'd10;
  localparam logic [ST_W-1:0]   FM_LOW_RST  = 12'd879;
  localparam logic [ST_W-1:0]   FM_HIGH_RST = 12'd1079;
  localparam logic [STEP_W-1:0] FM_STEP_RST = 8'd2;
  localparam logic [VOL_W-1:0]  VOL_MAX_RST = 7'd100;

  typedef enum logic [2:0] {
    KIND_POWER  = 3'd0,
    KIND_BAND   = 3'd1,
    KIND_UP     = 3'd2,
    KIND_DOWN   = 3'd3,
    KIND_VOLUME = 3'd4,
    KIND_STORE  = 3'd5,
    KIND_RECALL = 3'd6,
    KIND_TUNE   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_RADIO_OFF  = 3'd1,
    STAT_CLAMP_LOW  = 3'd2,
    STAT_CLAMP_HIGH = 3'd3,
    STAT_BAD_PRESET = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AM_LOW  = 3'd0,
    CFG_AM_HIGH = 3'd1,
    CFG_AM_STEP = 3'd2,
    CFG_FM_LOW  = 3'd3,
    CFG_FM_HIGH = 3'd4,
    CFG_FM_STEP = 3'd5,
    CFG_VOL_MAX = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [ST_W-1:0]   am_low;
    logic [ST_W-1:0]   am_high;
    logic [STEP_W-1:0] am_step;
    logic [ST_W-1:0]   fm_low;
    logic [ST_W-1:0]   fm_high;
    logic [STEP_W-1:0] fm_step;
    logic [VOL_W-1:0]  volume_max;
  } cfg_t;

  typedef struct packed {
    logic              is_on;
    logic              on_fm;
    logic [ST_W-1:0]   tuned;
    logic [VOL_W-1:0]  level;
    logic [VOL_W-1:0]  saved_level;
    logic              saved_fm;
    logic [ST_W-1:0]   last_am;
    logic [ST_W-1:0]   last_fm;
    logic [ST_W-1:0]   off_am;
    logic [ST_W-1:0]   off_fm;
  } radio_state_t;

  typedef struct packed {
    logic                    wr_en;
    logic                    fm;
    logic [PRESET_IDX_W-1:0] addr;
    logic [ST_W-1:0]         data;
  } preset_wr_t;

endpackage

// File: rtl/amfm_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces of the tuner controller
// depends on amfm_pkg for field widths

interface amfm_in_if
  import amfm_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               kind;
  logic signed [15:0]       volume_request;
  logic [3:0]               preset_index;
  logic [ST_W-1:0]          tune_value;
  modport source (output valid, kind, volume_request, preset_index, tune_value,
                  input ready);
  modport sink (input valid, kind, volume_request, preset_index, tune_value,
                output ready);
endinterface

interface amfm_out_if
  import amfm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic             power_on;
  logic             band_fm;
  logic [ST_W-1:0]  station;
  logic [VOL_W-1:0] volume_level;
  modport source (output valid, status, power_on, band_fm, station, volume_level,
                  input ready);
  modport sink (input valid, status, power_on, band_fm, station, volume_level,
                output ready);
endinterface

interface amfm_cfg_if
  import amfm_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/amfm_cfg_regs.sv
`timescale 1ns / 1ps
// configuration register file: band limits, scan steps, volume ceiling
// depends on amfm_pkg and the amfm_cfg_if interface
module amfm_cfg_regs
  import amfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  amfm_cfg_if.sink   cfg,
  output cfg_t       cfg_q
);

  cfg_t regs;

  assign cfg.ready = 1'b1;
  assign cfg_q     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.am_low     <= AM_LOW_RST;
      regs.am_high    <= AM_HIGH_RST;
      regs.am_step    <= AM_STEP_RST;
      regs.fm_low     <= FM_LOW_RST;
      regs.fm_high    <= FM_HIGH_RST;
      regs.fm_step    <= FM_STEP_RST;
      regs.volume_max <= VOL_MAX_RST;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_AM_LOW:  regs.am_low     <= cfg.data[ST_W-1:0];
        CFG_AM_HIGH: regs.am_high    <= cfg.data[ST_W-1:0];
        CFG_AM_STEP: regs.am_step    <= cfg.data[STEP_W-1:0];
        CFG_FM_LOW:  regs.fm_low     <= cfg.data[ST_W-1:0];
        CFG_FM_HIGH: regs.fm_high    <= cfg.data[ST_W-1:0];
        CFG_FM_STEP: regs.fm_step    <= cfg.data[STEP_W-1:0];
        CFG_VOL_MAX: regs.volume_max <= cfg.data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/amfm_presets.sv
`timescale 1ns / 1ps
// per-band preset station registers, one read port and one write port
// depends on amfm_pkg
module amfm_presets
  import amfm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_fm,
  input  logic [PRESET_IDX_W-1:0] rd_addr,
  output logic [ST_W-1:0]         rd_data,
  input  preset_wr_t              wr
);

  logic [ST_W-1:0] am_slots [PRESETS];
  logic [ST_W-1:0] fm_slots [PRESETS];

  always_comb begin
    rd_data = '0;
    if (32'(rd_addr) < PRESETS) begin
      rd_data = rd_fm ? fm_slots[rd_addr] : am_slots[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRESETS; i++) begin
        am_slots[i] <= AM_LOW_RST;
        fm_slots[i] <= FM_LOW_RST;
      end
    end else if (wr.wr_en && (32'(wr.addr) < PRESETS)) begin
      if (wr.fm) begin
        fm_slots[wr.addr] <= wr.data;
      end else begin
        am_slots[wr.addr] <= wr.data;
      end
    end
  end

endmodule

// File: rtl/amfm_step.sv
`timescale 1ns / 1ps
// next-state logic for one button request: power, band, scans, volume,
// presets and direct tune; depends on amfm_pkg
module amfm_step
  import amfm_pkg::*;
(
  input  cfg_t               cfg_q,
  input  radio_state_t       cur,
  input  logic [2:0]         kind,
  input  logic signed [15:0] volume_request,
  input  logic [3:0]         preset_index,
  input  logic [ST_W-1:0]    tune_value,
  input  logic [ST_W-1:0]    preset_rd,
  input  logic               accept,
  output radio_state_t       nxt,
  output status_t            status,
  output preset_wr_t         preset_wr
);

  logic [ST_W-1:0]   lo;
  logic [ST_W-1:0]   hi;
  logic [STEP_W-1:0] stp;
  logic [ST_W:0]     up_sum;
  logic [ST_W-1:0]   up_val;
  logic [ST_W-1:0]   down_val;
  logic [ST_W-1:0]   stp_ext;
  logic              idx_ok;
  logic              note;

  assign lo      = cur.on_fm ? cfg_q.fm_low  : cfg_q.am_low;
  assign hi      = cur.on_fm ? cfg_q.fm_high : cfg_q.am_high;
  assign stp     = cur.on_fm ? cfg_q.fm_step : cfg_q.am_step;
  assign stp_ext = {{(ST_W-STEP_W){1'b0}}, stp};
  assign up_sum  = {1'b0, cur.tuned} + {1'b0, stp_ext};
  // saturate at the top of the station field
  assign up_val   = up_sum[ST_W] ? {ST_W{1'b1}} : up_sum[ST_W-1:0];
  assign down_val = (stp_ext > cur.tuned) ? '0 : cur.tuned - stp_ext;
  assign idx_ok   = 32'(preset_index) < PRESETS;

  always_comb begin
    nxt            = cur;
    status         = STAT_OK;
    note           = 1'b0;
    preset_wr.wr_en = 1'b0;
    preset_wr.fm    = cur.on_fm;
    preset_wr.addr  = preset_index[PRESET_IDX_W-1:0];
    preset_wr.data  = cur.tuned;
    case (kind_t'(kind))
      KIND_POWER: begin
        if (cur.is_on) begin
          nxt.is_on       = 1'b0;
          nxt.saved_level = cur.level;
          nxt.level       = '0;
          nxt.saved_fm    = cur.on_fm;
          nxt.off_am      = cur.last_am;
          nxt.off_fm      = cur.last_fm;
        end else begin
          nxt.is_on = 1'b1;
          nxt.level = cur.saved_level;
          nxt.on_fm = cur.saved_fm;
          nxt.tuned = cur.saved_fm ? cur.off_fm : cur.off_am;
          note      = 1'b1;
        end
      end
      KIND_BAND: begin
        nxt.on_fm = !cur.on_fm;
        nxt.tuned = cur.on_fm ? cur.last_am : cur.last_fm;
      end
      KIND_UP: begin
        nxt.tuned = (cur.tuned >= hi) ? lo : up_val;
        note      = 1'b1;
      end
      KIND_DOWN: begin
        nxt.tuned = (cur.tuned <= lo) ? hi : down_val;
        note      = 1'b1;
      end
      KIND_VOLUME: begin
        if (!cur.is_on) begin
          status = STAT_RADIO_OFF;
        end else if (volume_request[15]) begin
          nxt.level = '0;
          status    = STAT_CLAMP_LOW;
        end else if (volume_request[14:0] > {{(15-VOL_W){1'b0}}, cfg_q.volume_max}) begin
          nxt.level = cfg_q.volume_max;
          status    = STAT_CLAMP_HIGH;
        end else begin
          nxt.level = volume_request[VOL_W-1:0];
        end
      end
      KIND_STORE: begin
        if (!idx_ok) begin
          status = STAT_BAD_PRESET;
        end else begin
          preset_wr.wr_en = accept;
        end
      end
      KIND_RECALL: begin
        if (!idx_ok) begin
          status = STAT_BAD_PRESET;
        end else begin
          nxt.tuned = preset_rd;
          note      = 1'b1;
        end
      end
      KIND_TUNE: begin
        if (tune_value <= lo) begin
          if (tune_value < lo) status = STAT_CLAMP_LOW;
          nxt.tuned = lo;
        end else if (tune_value >= hi) begin
          if (tune_value > hi) status = STAT_CLAMP_HIGH;
          nxt.tuned = hi;
        end else begin
          nxt.tuned = tune_value;
        end
        note = 1'b1;
      end
      default: ;
    endcase
    // band's last station follows the tuned station
    if (note) begin
      if (nxt.on_fm) begin
        nxt.last_fm = nxt.tuned;
      end else begin
        nxt.last_am = nxt.tuned;
      end
    end
  end

endmodule

// File: rtl/am_fm_tuner_controller.sv
`timescale 1ns / 1ps
// top level of the radio front-panel controller
// depends on amfm_pkg, the channel interfaces, amfm_cfg_regs, amfm_presets,
// amfm_step and the assertion macro header
// usage:
//   in_ch  carries one button request (kind, volume_request, preset_index,
//          tune_value); it is taken at a clock edge with valid and ready high
//   out_ch returns exactly one result per request: status code and the
//          power, band, station and volume seen after the request
//   cfg    writes one of seven registers (band limits, scan steps, volume
//          ceiling) by index; it is always ready, writes beyond the list are
//          dropped; write it only while no request is in flight
// result: registered, valid in the cycle after its request is taken
// throughput: one request per cycle while results are taken; the state update and
//   the result register load in the same cycle, so the rate is set by that single
//   compare/add path through amfm_step
// reset (rst, synchronous): radio off, AM band, station and all AM presets at
//   the AM low reset value, FM presets and FM memories at the FM low reset
//   value, volume 0, registers at their reset values, no result pending
// stall: while a result waits, a new request is still taken if the receiver
//   takes the waiting result in the same cycle; otherwise in_ch.ready drops
module am_fm_tuner_controller
  import amfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  amfm_in_if.sink     in_ch,
  amfm_out_if.source  out_ch,
  amfm_cfg_if.sink    cfg
);

`include "am_fm_tuner_controller_assert.svh"

  cfg_t            cfg_q;
  radio_state_t    state;
  radio_state_t    state_next;
  status_t         step_status;
  preset_wr_t      preset_wr;
  logic [ST_W-1:0] preset_rd;
  logic            in_acc;

  // result register
  logic             out_valid;
  logic [2:0]       out_status;
  logic             out_power;
  logic             out_band;
  logic [ST_W-1:0]  out_station;
  logic [VOL_W-1:0] out_level;

  // take a request when the result slot is empty or drains this cycle
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  amfm_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  amfm_presets u_presets (
    .clk     (clk),
    .rst     (rst),
    .rd_fm   (state.on_fm),
    .rd_addr (in_ch.preset_index[PRESET_IDX_W-1:0]),
    .rd_data (preset_rd),
    .wr      (preset_wr)
  );

  amfm_step u_step (
    .cfg_q          (cfg_q),
    .cur            (state),
    .kind           (in_ch.kind),
    .volume_request (in_ch.volume_request),
    .preset_index   (in_ch.preset_index),
    .tune_value     (in_ch.tune_value),
    .preset_rd      (preset_rd),
    .accept         (in_acc),
    .nxt            (state_next),
    .status         (step_status),
    .preset_wr      (preset_wr)
  );

  // radio state: updated once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state.is_on       <= 1'b0;
      state.on_fm       <= 1'b0;
      state.tuned       <= AM_LOW_RST;
      state.level       <= '0;
      state.saved_level <= '0;
      state.saved_fm    <= 1'b0;
      state.last_am     <= AM_LOW_RST;
      state.last_fm     <= FM_LOW_RST;
      state.off_am      <= AM_LOW_RST;
      state.off_fm      <= FM_LOW_RST;
    end else if (in_acc) begin
      state <= state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded with the state after the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status  <= step_status;
      out_power   <= state_next.is_on;
      out_band    <= state_next.on_fm;
      out_station <= state_next.tuned;
      out_level   <= state_next.level;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.power_on     = out_power;
  assign out_ch.band_fm      = out_band;
  assign out_ch.station      = out_station;
  assign out_ch.volume_level = out_level;

  // an empty result slot never blocks a request
  `AMFM_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ch.ready)
  // every taken request leaves a result behind
  `AMFM_ASSERT_NEXT(a_result_follows, clk, rst, in_acc, out_valid)
  // volume is muted whenever the radio is off
  `AMFM_ASSERT_NOW(a_off_is_muted, clk, rst, !state.is_on, state.level == '0)
  // reported power and band agree with the state just written
  `AMFM_ASSERT_NEXT(a_result_matches_state, clk, rst, in_acc,
                    (out_power == state.is_on) && (out_band == state.on_fm))

endmodule

// File: bench/amfm_tuner_checker.sv
`timescale 1ns / 1ps
// result checker for the tuner controller: watches the button, result and
// register channels, keeps its own copy of the radio and compares every result
// depends on amfm_pkg and the channel interfaces in amfm_ifs.sv
module amfm_tuner_checker
  import amfm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  amfm_in_if   in_mon,
  amfm_out_if  out_mon,
  amfm_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    status_t          status;
    logic             power_on;
    logic             band_fm;
    logic [ST_W-1:0]  station;
    logic [VOL_W-1:0] volume_level;
  } panel_view_t;

  // register copy
  logic [ST_W-1:0]   am_lo, am_hi, fm_lo, fm_hi;
  logic [STEP_W-1:0] am_stp, fm_stp;
  logic [VOL_W-1:0]  vol_ceiling;

  // radio copy
  logic              powered, fm_band, snap_band_fm;
  logic [ST_W-1:0]   station_now, last_am_st, last_fm_st, snap_am_st, snap_fm_st;
  logic [VOL_W-1:0]  vol_now, snap_vol;
  logic [ST_W-1:0]   am_memory [PRESETS];
  logic [ST_W-1:0]   fm_memory [PRESETS];

  panel_view_t expected_views [$];
  int mismatches = 0;

  function void reset_radio();
    am_lo = AM_LOW_RST; am_hi = AM_HIGH_RST; am_stp = AM_STEP_RST;
    fm_lo = FM_LOW_RST; fm_hi = FM_HIGH_RST; fm_stp = FM_STEP_RST;
    vol_ceiling = VOL_MAX_RST;
    powered = 1'b0; fm_band = 1'b0; snap_band_fm = 1'b0;
    station_now = AM_LOW_RST; vol_now = '0; snap_vol = '0;
    last_am_st = AM_LOW_RST; snap_am_st = AM_LOW_RST;
    last_fm_st = FM_LOW_RST; snap_fm_st = FM_LOW_RST;
    for (int i = 0; i < PRESETS; i++) begin
      am_memory[i] = AM_LOW_RST;
      fm_memory[i] = FM_LOW_RST;
    end
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (cfg_idx_t'(idx))
      CFG_AM_LOW:  am_lo = data;
      CFG_AM_HIGH: am_hi = data;
      CFG_AM_STEP: am_stp = data[STEP_W-1:0];
      CFG_FM_LOW:  fm_lo = data;
      CFG_FM_HIGH: fm_hi = data;
      CFG_FM_STEP: fm_stp = data[STEP_W-1:0];
      CFG_VOL_MAX: vol_ceiling = data[VOL_W-1:0];
      default: ;
    endcase
  endfunction

  // the band's last station follows every tuning move
  function void follow_band();
    if (fm_band) last_fm_st = station_now;
    else last_am_st = station_now;
  endfunction

  function panel_view_t press_button(kind_t k, logic signed [15:0] vreq,
                                     logic [3:0] idx, logic [ST_W-1:0] tv);
    logic [ST_W-1:0]         lo, hi;
    logic [STEP_W-1:0]       stp;
    logic [ST_W-1:0]         stp_wide;
    logic [ST_W:0]           sum;
    logic [PRESET_IDX_W-1:0] slot;
    status_t                 st;
    panel_view_t             view;
    lo = fm_band ? fm_lo : am_lo;
    hi = fm_band ? fm_hi : am_hi;
    stp = fm_band ? fm_stp : am_stp;
    stp_wide = {{(ST_W-STEP_W){1'b0}}, stp};
    slot = idx[PRESET_IDX_W-1:0];
    st = STAT_OK;
    case (k)
      KIND_POWER: begin
        if (powered) begin
          powered = 1'b0;
          snap_vol = vol_now;
          vol_now = '0;
          snap_band_fm = fm_band;
          snap_am_st = last_am_st;
          snap_fm_st = last_fm_st;
        end else begin
          powered = 1'b1;
          vol_now = snap_vol;
          fm_band = snap_band_fm;
          station_now = fm_band ? snap_fm_st : snap_am_st;
          follow_band();
        end
      end
      KIND_BAND: begin
        fm_band = !fm_band;
        station_now = fm_band ? last_fm_st : last_am_st;
      end
      KIND_UP: begin
        if (station_now >= hi) station_now = lo;
        else begin
          sum = {1'b0, station_now} + {1'b0, stp_wide};
          station_now = sum[ST_W] ? '1 : sum[ST_W-1:0];
        end
        follow_band();
      end
      KIND_DOWN: begin
        if (station_now <= lo) station_now = hi;
        else if (stp_wide > station_now) station_now = '0;
        else station_now = station_now - stp_wide;
        follow_band();
      end
      KIND_VOLUME: begin
        if (!powered) st = STAT_RADIO_OFF;
        else if (vreq < 0) begin
          vol_now = '0;
          st = STAT_CLAMP_LOW;
        end else if (vreq > 16'(vol_ceiling)) begin
          vol_now = vol_ceiling;
          st = STAT_CLAMP_HIGH;
        end else vol_now = vreq[VOL_W-1:0];
      end
      KIND_STORE: begin
        if (idx >= PRESETS) st = STAT_BAD_PRESET;
        else if (fm_band) fm_memory[slot] = station_now;
        else am_memory[slot] = station_now;
      end
      KIND_RECALL: begin
        if (idx >= PRESETS) st = STAT_BAD_PRESET;
        else begin
          station_now = fm_band ? fm_memory[slot] : am_memory[slot];
          follow_band();
        end
      end
      KIND_TUNE: begin
        // low test first, so with inverted limits any value up to the low limit lands on it
        if (tv <= lo) begin
          if (tv < lo) st = STAT_CLAMP_LOW;
          station_now = lo;
        end else if (tv >= hi) begin
          if (tv > hi) st = STAT_CLAMP_HIGH;
          station_now = hi;
        end else station_now = tv;
        follow_band();
      end
      default: ;
    endcase
    view.status = st;
    view.power_on = powered;
    view.band_fm = fm_band;
    view.station = station_now;
    view.volume_level = vol_now;
    return view;
  endfunction

  function void flag(string what, int want, int got);
    if (mismatches < 10)
      $display("%0t tuner mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endfunction

  function void compare_view(panel_view_t want, panel_view_t got);
    if (got.status !== want.status) flag("status", want.status, got.status);
    if (got.power_on !== want.power_on) flag("power_on", want.power_on, got.power_on);
    if (got.band_fm !== want.band_fm) flag("band_fm", want.band_fm, got.band_fm);
    if (got.station !== want.station) flag("station", want.station, got.station);
    if (got.volume_level !== want.volume_level)
      flag("volume_level", want.volume_level, got.volume_level);
  endfunction

  always @(posedge clk) begin
    panel_view_t got;
    if (rst) begin
      reset_radio();
      expected_views.delete();
    end else begin
      // a result leaves before a new request's prediction goes in
      if (out_mon.valid && out_mon.ready) begin
        got.status = status_t'(out_mon.status);
        got.power_on = out_mon.power_on;
        got.band_fm = out_mon.band_fm;
        got.station = out_mon.station;
        got.volume_level = out_mon.volume_level;
        if (expected_views.size() == 0) flag("result with nothing pending", 0, 1);
        else compare_view(expected_views.pop_front(), got);
      end
      if (cfg_mon.valid && cfg_mon.ready) write_register(cfg_mon.index, cfg_mon.data);
      if (in_mon.valid && in_mon.ready)
        expected_views.push_back(press_button(kind_t'(in_mon.kind), in_mon.volume_request,
                                              in_mon.preset_index, in_mon.tune_value));
    end
    fail_count <= mismatches;
    pending_count <= expected_views.size();
  end

endmodule

// File: bench/tb_am_fm_tuner_controller.sv
`timescale 1ns / 1ps
// testbench top of the tuner controller: drives button requests and register
// writes, stalls the result side, and gives the verdict from the checker
// depends on amfm_pkg, amfm_ifs.sv, amfm_tuner_checker and the block rtl
module tb_am_fm_tuner_controller;
  import amfm_pkg::*;

  localparam int RUN_LIMIT        = 200000;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int SETTLE_CYCLES    = 5;
  // one index past the register list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(int'(CFG_VOL_MAX) + 1);

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   fail_count, pending_count;
  int   send_gap_pct = 0;
  int   stall_pct = 0;

  // settings last written, used to aim random values near the limits
  logic [ST_W-1:0]  band_limits [4];
  logic [VOL_W-1:0] vol_cap;

  amfm_in_if  in_ch ();
  amfm_out_if out_ch ();
  amfm_cfg_if cfg ();

  am_fm_tuner_controller dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  amfm_tuner_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: ready drops in random bursts
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // one button request; valid is left high so back-to-back requests need
  // no second assignment in the same step
  task send_button(kind_t k, logic signed [15:0] vreq, logic [3:0] idx,
                   logic [ST_W-1:0] tv);
    if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.volume_request <= vreq;
    in_ch.preset_index <= idx;
    in_ch.tune_value <= tv;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold off until every result is back; the block has no request that
  // makes no result, so nothing can still be in flight after that
  task wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task load_settings(logic [ST_W-1:0] am_lo, logic [ST_W-1:0] am_hi,
                     logic [CFG_DATA_W-1:0] am_stp, logic [ST_W-1:0] fm_lo,
                     logic [ST_W-1:0] fm_hi, logic [CFG_DATA_W-1:0] fm_stp,
                     logic [CFG_DATA_W-1:0] vol_max);
    write_reg(CFG_AM_LOW, am_lo);
    write_reg(CFG_AM_HIGH, am_hi);
    write_reg(CFG_AM_STEP, am_stp);
    write_reg(CFG_FM_LOW, fm_lo);
    write_reg(CFG_FM_HIGH, fm_hi);
    write_reg(CFG_FM_STEP, fm_stp);
    write_reg(CFG_VOL_MAX, vol_max);
    cfg.valid <= 1'b0;
    band_limits = '{am_lo, am_hi, fm_lo, fm_hi};
    vol_cap = vol_max[VOL_W-1:0];
  endtask

  // random request: mostly scans, tuning and presets, few power toggles
  task random_button();
    kind_t             k;
    logic signed [15:0] vreq;
    logic [3:0]        idx;
    logic [ST_W-1:0]   tv;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) k = KIND_POWER;
    else if (pick < 12) k = KIND_BAND;
    else if (pick < 28) k = KIND_UP;
    else if (pick < 44) k = KIND_DOWN;
    else if (pick < 58) k = KIND_VOLUME;
    else if (pick < 68) k = KIND_STORE;
    else if (pick < 80) k = KIND_RECALL;
    else k = KIND_TUNE;
    case ($urandom_range(0, 3))
      0: vreq = 16'($urandom);
      1: vreq = 16'($urandom_range(0, 127));
      2: vreq = 16'(int'(vol_cap) + $urandom_range(0, 2) - 1);
      default: vreq = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
    // bad preset buttons now and then
    if ($urandom_range(0, 9) == 0) idx = 4'($urandom_range(PRESETS, 15));
    else idx = 4'($urandom_range(0, PRESETS - 1));
    // tune values straddle a band limit half the time
    if ($urandom_range(0, 1)) tv = 12'($urandom);
    else tv = band_limits[$urandom_range(0, 3)] + 12'($urandom_range(0, 2)) - 12'd1;
    send_button(k, vreq, idx, tv);
  endtask

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_POWER;
    in_ch.volume_request <= '0;
    in_ch.preset_index <= '0;
    in_ch.tune_value <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_AM_LOW;
    cfg.data <= '0;
    band_limits = '{AM_LOW_RST, AM_HIGH_RST, FM_LOW_RST, FM_HIGH_RST};
    vol_cap = VOL_MAX_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset settings; the radio starts off on AM
    send_button(KIND_VOLUME, 16'sd50, 4'd0, 12'd0);     // refused while off
    send_button(KIND_BAND, 16'sd0, 4'd0, 12'd0);        // band works while off
    send_button(KIND_TUNE, 16'sd0, 4'd0, 12'd0);        // below fm low
    send_button(KIND_POWER, 16'sd0, 4'd0, 12'd0);       // on, back to saved AM
    send_button(KIND_VOLUME, 16'sh8000, 4'd0, 12'd0);   // most negative request
    send_button(KIND_VOLUME, 16'sh7fff, 4'd0, 12'd0);   // above ceiling
    send_button(KIND_VOLUME, 16'sd100, 4'd0, 12'd0);    // exactly the ceiling
    send_button(KIND_VOLUME, 16'sd0, 4'd0, 12'd0);
    send_button(KIND_TUNE, 16'sd0, 4'd0, 12'd4095);     // above am high
    send_button(KIND_UP, 16'sd0, 4'd0, 12'd0);          // wraps to low
    send_button(KIND_DOWN, 16'sd0, 4'd0, 12'd0);        // wraps to high
    send_button(KIND_TUNE, 16'sd0, 4'd0, 12'd530);      // exact low, no clamp flag
    send_button(KIND_TUNE, 16'sd0, 4'd0, 12'd1700);     // exact high
    send_button(KIND_TUNE, 16'sd0, 4'd0, 12'd1000);
    send_button(KIND_STORE, 16'sd0, 4'd0, 12'd0);
    send_button(KIND_STORE, 16'sd0, 4'(PRESETS - 1), 12'd0);
    send_button(KIND_STORE, 16'sd0, 4'(PRESETS), 12'd0); // first bad index
    send_button(KIND_RECALL, 16'sd0, 4'd15, 12'd0);
    send_button(KIND_BAND, 16'sd0, 4'd0, 12'd0);
    send_button(KIND_RECALL, 16'sd0, 4'(PRESETS - 1), 12'd0); // untouched fm preset
    send_button(KIND_BAND, 16'sd0, 4'd0, 12'd0);
    send_button(KIND_RECALL, 16'sd0, 4'(PRESETS - 1), 12'd0);
    send_button(KIND_POWER, 16'sd0, 4'd0, 12'd0);       // off, snapshot taken
    send_button(KIND_POWER, 16'sd0, 4'd0, 12'd0);       // on, snapshot restored
    wait_idle();

    // each phase changes settings while idle, then runs random requests;
    // the drain at the end of each phase is the sender holding off
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          // widest bands and biggest AM step; scans saturate at both ends
          load_settings(12'd0, 12'd4095, 12'd255, 12'd0, 12'd4095, 12'd1, 12'd127);
          send_gap_pct = 30;
          stall_pct = 30;
          send_button(KIND_TUNE, 16'sd0, 4'd0, 12'd4000);
          send_button(KIND_UP, 16'sd0, 4'd0, 12'd0);
          send_button(KIND_TUNE, 16'sd0, 4'd0, 12'd100);
          send_button(KIND_DOWN, 16'sd0, 4'd0, 12'd0);
        end
        1: begin
          // inverted limits, smallest ceiling, plus a dropped write
          write_reg(CFG_UNUSED, 12'hfff);
          load_settings(12'd1700, 12'd530, 12'd1, 12'd1079, 12'd879, 12'd255, 12'd1);
          send_gap_pct = 0;
          stall_pct = 0;
        end
        2: begin
          // collapsed bands at both ends of the range
          load_settings(12'd4095, 12'd4095, 12'd128, 12'd0, 12'd0, 12'd255, 12'd64);
          send_gap_pct = 15;
          stall_pct = 15;
        end
        3, 4: begin
          // random settings; upper data bits beyond each register are junk
          load_settings(12'($urandom), 12'($urandom),
                        {4'($urandom), 8'($urandom_range(1, 255))},
                        12'($urandom), 12'($urandom),
                        {4'($urandom), 8'($urandom_range(1, 255))},
                        {5'($urandom), 7'($urandom_range(1, 127))});
          send_gap_pct = (p == 3) ? 15 : 40;
          stall_pct = (p == 3) ? 40 : 15;
        end
        default: begin
          // last stretch at full rate on the reset settings
          load_settings(AM_LOW_RST, AM_HIGH_RST, 12'(AM_STEP_RST), FM_LOW_RST,
                        FM_HIGH_RST, 12'(FM_STEP_RST), 12'(VOL_MAX_RST));
          send_gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) random_button();
      wait_idle();
    end

    // let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: am_fm_tuner_controller.f
+incdir+rtl
rtl/amfm_pkg.sv
rtl/amfm_ifs.sv
rtl/amfm_cfg_regs.sv
rtl/amfm_presets.sv
rtl/amfm_step.sv
rtl/am_fm_tuner_controller.sv
bench/amfm_tuner_checker.sv
bench/tb_am_fm_tuner_controller.sv
